FILE: sv/sklt_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the streaming kth-largest tracker
// no dependencies; imported by sklt_engine and the top level

package sklt_pkg;

    localparam int MAX_K_DEF = 64;  // default number of kept values
    localparam int VALUE_W   = 32;  // stream value width
    localparam int KSEL_W    = 7;   // k_select register width
    localparam int HCNT_W    = 7;   // held_count result width

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CMPMIN = 6'b000010,
        ST_SHIFT  = 6'b000100,
        ST_PLACE  = 6'b001000,
        ST_FIN    = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    // control from the top level to the engine
    typedef struct packed {
        logic start;   // item accepted, engine idle
        logic take;    // finished result moved to the output register
        logic cfg_we;  // new effective k written
    } t_eng_ctl;

    // status from the engine to the top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_sts;

endpackage

FILE: sv/streaming_kth_largest_tracker_core.sv
`timescale 1ns / 1ps
// top level of the streaming kth-largest tracker: handshakes, k register, result register
// depends on sklt_pkg and sklt_engine
//
// usage
//   input channel  i_in_valid / o_in_ready carries one signed 32-bit value per item
//   output channel o_out_valid / i_out_ready carries one result per item:
//     the smallest kept value, a full flag and the held count
//   config channel i_cfg_valid / o_cfg_ready writes k_select (7 bits); zero acts as 1,
//     values above MAX_K act as MAX_K; lowering k drops the smallest kept values at once
// timing
//   kept values live in a sorted ring buffer; one item is inserted by a shift loop that
//   moves one entry per cycle through the single memory write port
//   an item may pass through ST_CMPMIN when the set is full, ST_SHIFT while kept values
//   move up and ST_PLACE when the new value lands at the bottom, then ST_FIN and ST_DONE;
//   the engine is idle again the cycle after its result moves to the output register
// reset
//   held count cleared, k = 1, no result pending; memory contents need no clearing
// stalls
//   the result register holds while i_out_ready is low; a new item may be accepted
//   meanwhile and its result waits inside the engine until the register frees

module streaming_kth_largest_tracker_core #(
    parameter int MAX_K = sklt_pkg::MAX_K_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // item input
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [sklt_pkg::VALUE_W-1:0]   i_value,
    // result output
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [sklt_pkg::VALUE_W-1:0]   o_kth_value,
    output logic                                  o_is_full,
    output logic        [sklt_pkg::HCNT_W-1:0]    o_held_count,
    // k_select write
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [sklt_pkg::KSEL_W-1:0]    i_cfg_data
);
    import sklt_pkg::*;

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW = $clog2(MAX_K + 1);

    // clamp k_select into 1..MAX_K
    function automatic logic [CW-1:0] eff_k(input logic [KSEL_W-1:0] ksel);
        int k;
        k = int'(ksel);
        if (k == 0) begin
            k = 1;
        end
        if (k > MAX_K) begin
            k = MAX_K;
        end
        return CW'(k);
    endfunction

    t_eng_ctl                   ctl;
    t_eng_sts                   sts;
    logic signed [VALUE_W-1:0]  eng_kth;
    logic [CW-1:0]              eng_count;
    logic [CW+HCNT_W-1:0]       count_ext;     // held count widened before truncation

    logic [CW-1:0]              r_k_eff;
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_kth;
    logic                       r_full;
    logic [HCNT_W-1:0]          r_held;

    logic                       in_acc;
    logic                       cfg_acc;
    logic                       res_load;

    // both item and config writes only while the engine sits idle;
    // a pending config write goes first
    assign o_in_ready  = sts.idle && !i_cfg_valid;
    assign o_cfg_ready = sts.idle;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // finished result moves out when the output register is empty or being drained
    assign res_load = sts.done && (!r_out_valid || i_out_ready);

    assign ctl.start  = in_acc;
    assign ctl.take   = res_load;
    assign ctl.cfg_we = cfg_acc;

    assign count_ext = {{HCNT_W{1'b0}}, eng_count};

    sklt_engine #(
        .MAX_K (MAX_K),
        .AW    (AW),
        .CW    (CW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_value     (i_value),
        .i_k_eff     (cfg_acc ? eff_k(i_cfg_data) : r_k_eff),
        .o_kth_value (eng_kth),
        .o_count     (eng_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_eff     <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                r_k_eff <= eff_k(i_cfg_data);
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_kth  <= eng_kth;
            r_full <= (eng_count == r_k_eff);
            r_held <= count_ext[HCNT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kth_value  = r_kth;
    assign o_is_full    = r_full;
    assign o_held_count = r_held;

endmodule

FILE: sv/sklt_engine.sv
`timescale 1ns / 1ps
// sorted ring buffer of kept values with its insertion sequencer and shared compare
// depends on sklt_pkg

module sklt_engine #(
    parameter int MAX_K = sklt_pkg::MAX_K_DEF,
    parameter int AW    = (MAX_K > 1) ? $clog2(MAX_K) : 1,
    parameter int CW    = $clog2(MAX_K + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sklt_pkg::t_eng_ctl                    i_ctl,
    output sklt_pkg::t_eng_sts                    o_sts,
    input  logic signed [sklt_pkg::VALUE_W-1:0]   i_value,
    input  logic        [CW-1:0]                  i_k_eff,
    output logic signed [sklt_pkg::VALUE_W-1:0]   o_kth_value,
    output logic        [CW-1:0]                  o_count
);
    import sklt_pkg::*;

    localparam logic [AW:0] KMOD = (AW + 1)'(MAX_K);

    // logical position j from the ring base to a physical address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] j);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, j};
        if (sum >= KMOD) begin
            sum = sum - KMOD;
        end
        return sum[AW-1:0];
    endfunction

    t_state                     r_state, n_state;
    logic [AW-1:0]              r_base,  n_base;
    logic [CW-1:0]              r_count, n_count;
    logic [AW-1:0]              r_i,     n_i;
    logic signed [VALUE_W-1:0]  r_x,     n_x;

    logic signed [VALUE_W-1:0]  r_mem [MAX_K];
    logic signed [VALUE_W-1:0]  r_rd_data;

    logic                       we;
    logic [AW-1:0]              wa;
    logic signed [VALUE_W-1:0]  wd;
    logic                       rd_en;
    logic [AW-1:0]              ra;

    logic                       x_gt;     // shared compare: held item x above read data
    logic [CW-1:0]              cnt_m1;
    logic [CW-1:0]              drop;
    logic [AW-1:0]              i_m1;
    logic [AW-1:0]              i_m2;

    assign x_gt   = (r_x > r_rd_data);
    assign cnt_m1 = r_count - 1'b1;
    assign drop   = r_count - i_k_eff;
    assign i_m1   = r_i - 1'b1;
    assign i_m2   = r_i - AW'(2);

    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        n_count = r_count;
        n_i     = r_i;
        n_x     = r_x;
        we      = 1'b0;
        wa      = r_base;
        wd      = r_x;
        rd_en   = 1'b0;
        ra      = r_base;
        case (r_state)
            ST_IDLE: begin
                if (i_ctl.cfg_we && (r_count > i_k_eff)) begin
                    // drop the smallest values by moving the ring base
                    n_base  = phys(r_base, drop[AW-1:0]);
                    n_count = i_k_eff;
                end else if (i_ctl.start) begin
                    n_x = i_value;
                    if (r_count >= i_k_eff) begin
                        rd_en   = 1'b1;
                        ra      = r_base;
                        n_state = ST_CMPMIN;
                    end else if (r_count == '0) begin
                        we      = 1'b1;
                        wa      = r_base;
                        wd      = i_value;
                        n_count = r_count + 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        rd_en   = 1'b1;
                        ra      = phys(r_base, cnt_m1[AW-1:0]);
                        n_i     = r_count[AW-1:0];
                        n_count = r_count + 1'b1;
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_CMPMIN: begin
                if (x_gt) begin
                    // evict the minimum, then insert among the rest
                    n_base = phys(r_base, AW'(1));
                    if (r_count == CW'(1)) begin
                        we      = 1'b1;
                        wa      = phys(r_base, AW'(1));
                        n_state = ST_FIN;
                    end else begin
                        rd_en   = 1'b1;
                        ra      = phys(r_base, cnt_m1[AW-1:0]);
                        n_i     = cnt_m1[AW-1:0];
                        n_state = ST_SHIFT;
                    end
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_SHIFT: begin
                wa = phys(r_base, r_i);
                we = 1'b1;
                // equal values move up too, the kept set is the same
                if (!x_gt) begin
                    wd  = r_rd_data;
                    n_i = i_m1;
                    if (r_i > AW'(1)) begin
                        rd_en = 1'b1;
                        ra    = phys(r_base, i_m2);
                    end else begin
                        n_state = ST_PLACE;
                    end
                end else begin
                    wd      = r_x;
                    n_state = ST_FIN;
                end
            end
            ST_PLACE: begin
                we      = 1'b1;
                wa      = phys(r_base, r_i);
                n_state = ST_FIN;
            end
            ST_FIN: begin
                rd_en   = 1'b1;
                ra      = r_base;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_ctl.take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_base  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_x <= n_x;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[ra];
        end
    end

    assign o_sts.idle  = (r_state == ST_IDLE);
    assign o_sts.done  = (r_state == ST_DONE);
    assign o_kth_value = r_rd_data;
    assign o_count     = r_count;

    a_count_le_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.cfg_we || (r_count <= i_k_eff))
        else $error("held count above k");

    a_done_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_count != '0))
        else $error("result with empty set");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_ctl.start && !i_ctl.cfg_we && r_count < i_k_eff)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow held count");

    a_evict_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMPMIN) |=> (r_count == $past(r_count)))
        else $error("eviction changed held count");

endmodule

FILE: tb/tb_streaming_kth_largest_tracker_core.sv
`timescale 1ns / 1ps
// self-checking testbench for streaming_kth_largest_tracker_core: a sorted top-k tracker
// predicts each result, directed and random values, k_select changes, idle and stall phases
// depends on sklt_pkg and the streaming_kth_largest_tracker_core rtl

module tb_streaming_kth_largest_tracker_core;

    import sklt_pkg::*;

    localparam int TOP_K_MAX     = MAX_K_DEF;
    localparam int QUIET_LIMIT   = 5000;   // cycles with no handshake at all before giving up
    localparam int HOLD_OFF_LEN  = 400;    // long receiver hold-off for the back-pressure test
    localparam int SETTLE_CYCLES = TOP_K_MAX + 16;  // worst insert latency plus margin
    localparam int MAX_PRINTED   = 30;

    // shapes of random value runs
    typedef enum int {
        PAT_UNIFORM,
        PAT_TIES,
        PAT_RISING,
        PAT_FALLING,
        PAT_EDGES
    } value_pattern_e;

    // one expected result item
    typedef struct packed {
        logic signed [VALUE_W-1:0] kth;
        logic                      full;
        logic [HCNT_W-1:0]         held;
    } kth_result_t;

    // dut signals; the inputs are known from time zero
    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_ready;
    logic signed [VALUE_W-1:0] i_value      = '0;
    logic                      o_out_valid;
    logic                      i_out_ready  = 1'b0;
    logic signed [VALUE_W-1:0] o_kth_value;
    logic                      o_is_full;
    logic [HCNT_W-1:0]         o_held_count;
    logic                      i_cfg_valid  = 1'b0;
    logic                      o_cfg_ready;
    logic [KSEL_W-1:0]         i_cfg_data   = '0;

    // predictor state: kept values in ascending order, count and the k register
    logic signed [VALUE_W-1:0] top_vals [0:TOP_K_MAX-1];
    int                        top_cnt;
    logic [KSEL_W-1:0]         ksel_shadow;
    kth_result_t               pending_results [$];

    // traffic shaping, set by the test tasks
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_req      = 0;   // bumped by a test to ask for one long hold-off
    int hold_seen     = 0;
    int hold_left     = 0;

    // run statistics
    int items_sent    = 0;
    int results_seen  = 0;
    int k_writes      = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    streaming_kth_largest_tracker_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kth_value  (o_kth_value),
        .o_is_full    (o_is_full),
        .o_held_count (o_held_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    // zero acts as one, anything above the depth saturates
    function automatic int rank_k(input logic [KSEL_W-1:0] ks);
        if (ks == '0) begin
            return 1;
        end
        if (int'(ks) > TOP_K_MAX) begin
            return TOP_K_MAX;
        end
        return int'(ks);
    endfunction

    // k write: lowering k drops the smallest kept values right away
    task automatic apply_k_write(input logic [KSEL_W-1:0] data);
        int k;
        int drop;
        ksel_shadow = data;
        k = rank_k(data);
        if (top_cnt > k) begin
            drop = top_cnt - k;
            for (int i = 0; i < k; i++) begin
                top_vals[i] = top_vals[i + drop];
            end
            top_cnt = k;
        end
    endtask

    // one accepted value: insert while not full, else replace the minimum if strictly greater
    task automatic track_value(input logic signed [VALUE_W-1:0] v);
        int          k;
        int          i;
        kth_result_t r;
        k = rank_k(ksel_shadow);
        if (top_cnt >= k) begin
            if (v > top_vals[0]) begin
                i = 0;
                while (i + 1 < top_cnt && top_vals[i + 1] < v) begin
                    top_vals[i] = top_vals[i + 1];
                    i++;
                end
                top_vals[i] = v;
            end
        end else begin
            i = top_cnt;
            while (i > 0 && top_vals[i - 1] > v) begin
                top_vals[i] = top_vals[i - 1];
                i--;
            end
            top_vals[i] = v;
            top_cnt++;
        end
        r.kth  = top_vals[0];
        r.full = (top_cnt == k);
        r.held = HCNT_W'(top_cnt);
        pending_results.push_back(r);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
    endtask

    // each result item is compared with the oldest expectation
    always @(posedge i_clk) begin
        kth_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected, kth_value", o_kth_value, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_kth_value !== want.kth) begin
                    report_mismatch("kth_value", o_kth_value, want.kth);
                end
                if (o_is_full !== want.full) begin
                    report_mismatch("is_full", o_is_full, want.full);
                end
                if (o_held_count !== want.held) begin
                    report_mismatch("held_count", o_held_count, want.held);
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off counted here on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_OFF_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers

    // send one item; valid stays high after acceptance so the caller must
    // follow with another item or a lowering of valid in the same step
    task automatic send_value(input logic signed [VALUE_W-1:0] v);
        if ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do @(posedge i_clk); while (!o_in_ready);
        track_value(v);
        items_sent++;
    endtask

    // stop offering items and wait until every result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // k_select is only written while the block is idle
    task automatic write_k(input logic [KSEL_W-1:0] data);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_k_write(data);
        k_writes++;
    endtask

    // k from 2 to 8 or anywhere up to full depth, with regular visits to 1, full depth, zero and saturation
    function automatic logic [KSEL_W-1:0] pick_k();
        int r;
        r = $urandom_range(9);
        case (r)
            0:       return KSEL_W'(1);
            1:       return KSEL_W'(TOP_K_MAX);
            2:       return KSEL_W'(0);
            3:       return KSEL_W'(127);
            4:       return KSEL_W'($urandom_range(126, TOP_K_MAX + 1));
            5, 6:    return KSEL_W'($urandom_range(8, 2));
            default: return KSEL_W'($urandom_range(TOP_K_MAX, 1));
        endcase
    endfunction

    // random traffic in runs of one shape, k changed every 40 to 130 items
    task automatic run_random_traffic(input int n_items);
        int                        left;
        int                        chunk;
        int                        run_left;
        value_pattern_e            pat;
        logic signed [VALUE_W-1:0] v;
        logic signed [VALUE_W-1:0] step;
        left     = n_items;
        pat      = PAT_UNIFORM;
        v        = '0;
        step     = 1;
        while (left > 0) begin
            write_k(pick_k());
            chunk = $urandom_range(130, 40);
            if (chunk > left) begin
                chunk = left;
            end
            run_left = 0;
            for (int j = 0; j < chunk; j++) begin
                if (run_left == 0) begin
                    pat      = value_pattern_e'($urandom_range(4));
                    run_left = $urandom_range(40, 6);
                    v        = $urandom;
                    step     = $urandom_range(1000, 1);
                end
                case (pat)
                    PAT_UNIFORM: v = $urandom;
                    PAT_TIES: begin
                        // narrow range so equal values hit the minimum often
                        v = $urandom_range(16);
                        v = v - 8;
                    end
                    PAT_RISING:  v = v + step;   // each value above the one before in the run, unless it wraps
                    PAT_FALLING: v = v - step;   // each value below the one before in the run, unless it wraps
                    default: begin
                        case ($urandom_range(3))
                            0:       v = 32'sh8000_0000;
                            1:       v = 32'sh7fff_ffff;
                            2:       v = 32'sh8000_0001;
                            default: v = 32'sh7fff_fffe;
                        endcase
                    end
                endcase
                send_value(v);
                run_left--;
            end
            left -= chunk;
        end
    endtask

    // ---------------------------------------------------------------- tests

    // k from reset is 1: extremes, equal to the minimum, smaller values ignored
    task automatic test_extremes_at_reset_k();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_value(32'sh8000_0000);
        send_value(32'sh7fff_ffff);
        send_value(32'sh7fff_ffff);   // equal to minimum, no replacement
        send_value(32'sh0000_0000);
        send_value(32'shffff_ffff);
        send_value(32'sh8000_0000);
    endtask

    // zero acts as 1, 127 saturates to full depth
    task automatic test_zero_and_saturated_k();
        write_k(KSEL_W'(0));
        send_value(32'sh0000_0005);
        send_value(32'sh0000_0007);
        write_k(KSEL_W'(127));
        send_value(32'shffff_fffb);
        send_value(32'sh8000_0000);
    endtask

    // lowering k below the held count drops the smallest; raising keeps the set
    task automatic test_k_lower_and_raise();
        write_k(KSEL_W'(4));   // three values held, below the new k, so none are dropped
        send_value(32'sh0000_0003);
        send_value(32'sh0000_0003);
        send_value(32'sh0000_0009);
        send_value(32'sh0000_0001);
        write_k(KSEL_W'(2));
        send_value(32'sh0000_0002);
        send_value(32'sh0000_000a);
        write_k(KSEL_W'(6));
        send_value(32'sh8000_0000);
        send_value(32'sh7fff_ffff);
        send_value(32'sh0000_000a);
        send_value(32'sh0000_000a);
        send_value(32'sh0000_000b);
    endtask

    task automatic test_random_no_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random_traffic(360);
    endtask

    task automatic test_random_sender_idle();
        src_idle_pct   = 65;
        sink_stall_pct = 0;
        run_random_traffic(360);
    endtask

    task automatic test_random_receiver_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 65;
        run_random_traffic(360);
    endtask

    task automatic test_random_both_idle();
        src_idle_pct   = 23;
        sink_stall_pct = 23;
        run_random_traffic(360);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering items
    task automatic test_backpressure_fill();
        write_k(KSEL_W'(16));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req++;
        for (int j = 0; j < 120; j++) begin
            send_value($urandom);
        end
    endtask

    // ---------------------------------------------------------------- main

    initial begin
        top_cnt     = 0;
        ksel_shadow = KSEL_W'(1);
        for (int i = 0; i < TOP_K_MAX; i++) begin
            top_vals[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes_at_reset_k();
        test_zero_and_saturated_k();
        test_k_lower_and_raise();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure_fill();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results still outstanding", pending_results.size(), 0);
        end

        $display("summary: %0d items sent, %0d results checked, %0d k_select writes",
                 items_sent, results_seen, k_writes);
        $display("summary: k zero, one, full depth and saturated; ties, ramps, extremes; %s",
                 "idle, stall and long hold-off phases");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/sklt_pkg.sv
sv/sklt_engine.sv
sv/streaming_kth_largest_tracker_core.sv
tb/tb_streaming_kth_largest_tracker_core.sv
